// ===== rtl/core/ssq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the supply stable qualifier.
// Holds the phase type, counter widths and register address codes; no dependencies.
package ssq_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int TIMEOUT_W    = 16;
    localparam int PERIOD_W     = 10;
    localparam int STABLE_W     = 16;
    localparam int CMP_W        = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = {COUNT_WIDTH{1'b1}};
    localparam logic [PERIOD_W-1:0]    PERIOD_MAX = {PERIOD_W{1'b1}};

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1);
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = PERIOD_W'(10);
    localparam logic [STABLE_W-1:0]  STABLE_RESET  = STABLE_W'(100);

    localparam logic [ADDR_W-1:0] ADDR_READY_TIMEOUT = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_CHECK_PERIOD  = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_STABLE_TIME   = 4'h8;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_WAIT     = 3'd1,
        PH_SAMPLE   = 3'd2,
        PH_PASS     = 3'd3,
        PH_CLKFAULT = 3'd4,
        PH_TIMEOUT  = 3'd5
    } phase_t;

endpackage

// ===== rtl/core/supply_stable_qualifier.sv =====
`timescale 1ns / 1ps
// Top level of the supply stable qualifier: power-good debounce timer.
// Depends on ssq_pkg for the phase type, widths and register addresses.
//
// Usage:
// Each item on the input channel (in_valid/in_ready) is one millisecond tick
// carrying start_req, clock_ready, monitor_ready and supply_above.
// Each accepted item produces exactly one item on the output channel
// (out_valid/out_ready) with the phase after that tick in status and the
// monitor power request in monitor_enable.
// The result is registered at the edge that accepts the item. Throughput is
// one item per cycle while the receiver takes each output, set by the single
// registered state update and the output register.
// When the receiver stalls, the output register holds its item and in_ready
// drops; when the output is taken in the same cycle, a new item is accepted.
// The APB port sets the ready timeout (0x0), the check period (0x4) and the
// stable time (0x8); the user must write it only while no item is in flight;
// the block does not enforce this. Reset returns the phase to idle, clears
// all counters and loads the register defaults of 1, 10 and 100 ticks.
module supply_stable_qualifier
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssq_pkg::ADDR_W-1:0]    paddr,
    input  logic [ssq_pkg::DATA_W-1:0]    pwdata,
    output logic [ssq_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          start_req,
    input  logic                          clock_ready,
    input  logic                          monitor_ready,
    input  logic                          supply_above,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic                          monitor_enable
);
    import ssq_pkg::*;

    logic [TIMEOUT_W-1:0]   timeout_reg;
    logic [PERIOD_W-1:0]    period_reg;
    logic [STABLE_W-1:0]    stable_reg;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] ready_elapsed_reg, ready_elapsed_next;
    logic [PERIOD_W-1:0]    period_count_reg, period_count_next;
    logic                   tracking_reg, tracking_next;
    logic [COUNT_WIDTH-1:0] stable_elapsed_reg, stable_elapsed_next;

    logic                   out_valid_reg;
    logic [2:0]             status_reg;
    logic                   monitor_enable_reg;

    logic                   cfg_write;
    logic                   accept;
    logic [TIMEOUT_W-1:0]   timeout_eff;
    logic [PERIOD_W-1:0]    period_eff;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            period_reg  <= PERIOD_RESET;
            stable_reg  <= STABLE_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr)
                ADDR_READY_TIMEOUT: timeout_reg <= pwdata[TIMEOUT_W-1:0];
                ADDR_CHECK_PERIOD:  period_reg  <= pwdata[PERIOD_W-1:0];
                ADDR_STABLE_TIME:   stable_reg  <= pwdata[STABLE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_READY_TIMEOUT: prdata = DATA_W'(timeout_reg);
            ADDR_CHECK_PERIOD:  prdata = DATA_W'(period_reg);
            ADDR_STABLE_TIME:   prdata = DATA_W'(stable_reg);
            default:            prdata = '0;
        endcase
    end

    assign in_ready    = !out_valid_reg || out_ready;
    assign accept      = in_valid && in_ready;
    assign timeout_eff = (timeout_reg == '0) ? TIMEOUT_W'(1) : timeout_reg;
    assign period_eff  = (period_reg == '0) ? PERIOD_W'(1) : period_reg;

    always_comb
    begin
        logic [COUNT_WIDTH-1:0] re_inc;
        logic [PERIOD_W-1:0]    pc_inc;
        logic [COUNT_WIDTH-1:0] se_inc;

        re_inc = (ready_elapsed_reg == COUNT_MAX) ? COUNT_MAX
                 : ready_elapsed_reg + COUNT_WIDTH'(1);
        pc_inc = (period_count_reg == PERIOD_MAX) ? PERIOD_MAX
                 : period_count_reg + PERIOD_W'(1);
        se_inc = (!tracking_reg) ? stable_elapsed_reg
                 : (stable_elapsed_reg == COUNT_MAX) ? COUNT_MAX
                 : stable_elapsed_reg + COUNT_WIDTH'(1);

        phase_next          = phase_reg;
        ready_elapsed_next  = ready_elapsed_reg;
        period_count_next   = period_count_reg;
        tracking_next       = tracking_reg;
        stable_elapsed_next = stable_elapsed_reg;

        if (start_req && phase_reg != PH_WAIT && phase_reg != PH_SAMPLE)
        begin
            ready_elapsed_next  = '0;
            period_count_next   = '0;
            tracking_next       = 1'b0;
            stable_elapsed_next = '0;
            if (!clock_ready)
            begin
                phase_next = PH_CLKFAULT;
            end
            else if (monitor_ready)
            begin
                phase_next = PH_SAMPLE;
            end
            else
            begin
                phase_next = PH_WAIT;
            end
        end
        else if (phase_reg == PH_WAIT)
        begin
            ready_elapsed_next = re_inc;
            if (monitor_ready)
            begin
                phase_next        = PH_SAMPLE;
                period_count_next = '0;
            end
            else if (CMP_W'(re_inc) >= CMP_W'(timeout_eff))
            begin
                phase_next = PH_TIMEOUT;
            end
        end
        else if (phase_reg == PH_SAMPLE)
        begin
            period_count_next   = pc_inc;
            stable_elapsed_next = se_inc;
            if (pc_inc >= period_eff)
            begin
                period_count_next = '0;
                if (!supply_above)
                begin
                    tracking_next       = 1'b0;
                    stable_elapsed_next = '0;
                end
                else if (stable_reg == '0)
                begin
                    phase_next = PH_PASS;
                end
                else if (!tracking_reg)
                begin
                    tracking_next       = 1'b1;
                    stable_elapsed_next = '0;
                end
                else if (CMP_W'(se_inc) >= CMP_W'(stable_reg))
                begin
                    phase_next = PH_PASS;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            ready_elapsed_reg  <= '0;
            period_count_reg   <= '0;
            tracking_reg       <= 1'b0;
            stable_elapsed_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg          <= phase_next;
                ready_elapsed_reg  <= ready_elapsed_next;
                period_count_reg   <= period_count_next;
                tracking_reg       <= tracking_next;
                stable_elapsed_reg <= stable_elapsed_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg         <= phase_next;
            monitor_enable_reg <= (phase_next == PH_WAIT) || (phase_next == PH_SAMPLE);
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign monitor_enable = monitor_enable_reg;

endmodule
